### rtl/ehp_pkg.sv
// Shared types, status codes and header field layout for the object file header parser.
`timescale 1ns / 1ps

package ehp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } ehp_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic        is_64bit;
    logic        big_endian;
    logic [15:0] object_type;
    logic [15:0] machine;
    logic [63:0] entry_point;
    logic [63:0] program_header_offset;
    logic [63:0] section_header_offset;
    logic [31:0] header_flags;
    logic [15:0] program_header_count;
    logic [15:0] section_count;
    logic [15:0] string_section_index;
  } ehp_out_t;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_MAGIC    = 4'd1;
  localparam logic [3:0] ST_CLASS    = 4'd2;
  localparam logic [3:0] ST_ENCODING = 4'd3;
  localparam logic [3:0] ST_IDVER    = 4'd4;
  localparam logic [3:0] ST_PAD      = 4'd5;
  localparam logic [3:0] ST_EVERSION = 4'd6;
  localparam logic [3:0] ST_STRNDX   = 4'd7;
  localparam logic [3:0] ST_TRUNC    = 4'd8;

  localparam logic [6:0] IDENT_LEN = 7'd16;

  localparam logic [7:0] MAG0 = 8'h7F;
  localparam logic [7:0] MAG1 = 8'h45;  // 'E'
  localparam logic [7:0] MAG2 = 8'h4C;  // 'L'
  localparam logic [7:0] MAG3 = 8'h46;  // 'F'

  // ident byte positions
  localparam logic [6:0] ID_MAG0    = 7'd0;
  localparam logic [6:0] ID_MAG1    = 7'd1;
  localparam logic [6:0] ID_MAG2    = 7'd2;
  localparam logic [6:0] ID_MAG3    = 7'd3;
  localparam logic [6:0] ID_CLASS   = 7'd4;
  localparam logic [6:0] ID_DATA    = 7'd5;
  localparam logic [6:0] ID_VERSION = 7'd6;
  localparam logic [6:0] ID_OSABI   = 7'd7;
  localparam logic [6:0] ID_ABIVER  = 7'd8;

  typedef enum logic [3:0] {
    FLD_TYPE, FLD_MACHINE, FLD_VERSION, FLD_ENTRY, FLD_PHOFF, FLD_SHOFF,
    FLD_FLAGS, FLD_EHSIZE, FLD_PHENTSIZE, FLD_PHNUM, FLD_SHENTSIZE,
    FLD_SHNUM, FLD_SHSTRNDX
  } fld_t;

  typedef struct packed {
    logic       valid;
    fld_t       id;
    logic [2:0] off;
    logic       first;
    logic       last;
  } fld_loc_t;

  // Map a byte position past the ident to its header field.
  function automatic fld_loc_t fld_locate(input logic [6:0] pos, input logic is64);
    logic [6:0] a;
    logic [6:0] tail;
    logic [6:0] start;
    logic [6:0] len;
    fld_loc_t   loc;
    a     = is64 ? 7'd8 : 7'd4;
    tail  = is64 ? 7'd48 : 7'd36;
    start = 7'd0;
    len   = 7'd2;
    loc   = '0;
    loc.valid = 1'b1;
    if (pos < 7'd18) begin
      loc.id = FLD_TYPE;      start = 7'd16;
    end else if (pos < 7'd20) begin
      loc.id = FLD_MACHINE;   start = 7'd18;
    end else if (pos < 7'd24) begin
      loc.id = FLD_VERSION;   start = 7'd20; len = 7'd4;
    end else if (pos < 7'd24 + a) begin
      loc.id = FLD_ENTRY;     start = 7'd24; len = a;
    end else if (pos < 7'd24 + a + a) begin
      loc.id = FLD_PHOFF;     start = 7'd24 + a; len = a;
    end else if (pos < tail) begin
      loc.id = FLD_SHOFF;     start = 7'd24 + a + a; len = a;
    end else if (pos < tail + 7'd4) begin
      loc.id = FLD_FLAGS;     start = tail; len = 7'd4;
    end else if (pos < tail + 7'd6) begin
      loc.id = FLD_EHSIZE;    start = tail + 7'd4;
    end else if (pos < tail + 7'd8) begin
      loc.id = FLD_PHENTSIZE; start = tail + 7'd6;
    end else if (pos < tail + 7'd10) begin
      loc.id = FLD_PHNUM;     start = tail + 7'd8;
    end else if (pos < tail + 7'd12) begin
      loc.id = FLD_SHENTSIZE; start = tail + 7'd10;
    end else if (pos < tail + 7'd14) begin
      loc.id = FLD_SHNUM;     start = tail + 7'd12;
    end else if (pos < tail + 7'd16) begin
      loc.id = FLD_SHSTRNDX;  start = tail + 7'd14;
    end else begin
      loc.valid = 1'b0;
      start = pos;
    end
    loc.off   = 3'(pos - start);
    loc.first = (pos == start);
    loc.last  = (pos == start + len - 7'd1);
    return loc;
  endfunction

endpackage

### rtl/ehp_core.sv
// Byte-wise header decode: position tracking, ident checks and field assembly.
`timescale 1ns / 1ps

module ehp_core import ehp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  ehp_in_t  item,
  output logic     res_valid,
  output ehp_out_t res
);

  logic [6:0]  pos, pos_next;
  logic        finished, finished_next;
  logic        is64, is64_next;
  logic        big, big_next;
  logic [63:0] acc, acc_next;
  logic [15:0] held_type, held_type_next;
  logic [15:0] held_machine, held_machine_next;
  logic [63:0] held_entry, held_entry_next;
  logic [63:0] held_phoff, held_phoff_next;
  logic [63:0] held_shoff, held_shoff_next;
  logic [31:0] held_flags, held_flags_next;
  logic [15:0] held_phnum, held_phnum_next;
  logic [15:0] held_shnum, held_shnum_next;

  fld_loc_t    loc;
  logic [63:0] acc_base;
  logic [63:0] acc_new;
  logic [7:0]  b;
  logic [3:0]  err;

  assign b   = item.data_byte;
  assign loc = fld_locate(pos, is64);

  always_comb begin
    acc_base = loc.first ? 64'd0 : acc;
    if (big) begin
      acc_new = {acc_base[55:0], b};
    end else begin
      acc_new = acc_base | (64'(b) << {loc.off, 3'b000});
    end
  end

  // ident checks
  always_comb begin
    err = ST_OK;
    case (pos)
      ID_MAG0:    if (b != MAG0) err = ST_MAGIC;
      ID_MAG1:    if (b != MAG1) err = ST_MAGIC;
      ID_MAG2:    if (b != MAG2) err = ST_MAGIC;
      ID_MAG3:    if (b != MAG3) err = ST_MAGIC;
      ID_CLASS:   if (b != 8'd1 && b != 8'd2) err = ST_CLASS;
      ID_DATA:    if (b != 8'd1 && b != 8'd2) err = ST_ENCODING;
      ID_VERSION: if (b != 8'd1) err = ST_IDVER;
      ID_OSABI, ID_ABIVER: err = ST_OK;
      default:    if (b != 8'd0) err = ST_PAD;
    endcase
  end

  always_comb begin
    pos_next          = pos;
    finished_next     = finished;
    is64_next         = is64;
    big_next          = big;
    acc_next          = acc;
    held_type_next    = held_type;
    held_machine_next = held_machine;
    held_entry_next   = held_entry;
    held_phoff_next   = held_phoff;
    held_shoff_next   = held_shoff;
    held_flags_next   = held_flags;
    held_phnum_next   = held_phnum;
    held_shnum_next   = held_shnum;
    res_valid         = 1'b0;
    res               = '0;

    if (step) begin
      if (item.end_of_stream) begin
        pos_next      = '0;
        finished_next = 1'b0;
        is64_next     = 1'b0;
        big_next      = 1'b0;
        acc_next      = '0;
        res_valid     = !finished;
        res.status    = ST_TRUNC;
      end else if (!finished) begin
        pos_next = pos + 7'd1;
        if (pos < IDENT_LEN) begin
          if (pos == ID_CLASS) is64_next = (b == 8'd2);
          if (pos == ID_DATA)  big_next  = (b == 8'd2);
          if (err != ST_OK) begin
            res_valid     = 1'b1;
            res.status    = err;
            finished_next = 1'b1;
          end
        end else if (!loc.valid) begin
          finished_next = 1'b1;
        end else begin
          acc_next = acc_new;
          if (loc.last) begin
            case (loc.id)
              FLD_TYPE:    held_type_next    = acc_new[15:0];
              FLD_MACHINE: held_machine_next = acc_new[15:0];
              FLD_VERSION: begin
                if (acc_new[31:0] != 32'd1) begin
                  res_valid     = 1'b1;
                  res.status    = ST_EVERSION;
                  finished_next = 1'b1;
                end
              end
              FLD_ENTRY:   held_entry_next   = acc_new;
              FLD_PHOFF:   held_phoff_next   = acc_new;
              FLD_SHOFF:   held_shoff_next   = acc_new;
              FLD_FLAGS:   held_flags_next   = acc_new[31:0];
              FLD_PHNUM:   held_phnum_next   = acc_new[15:0];
              FLD_SHNUM:   held_shnum_next   = acc_new[15:0];
              FLD_SHSTRNDX: begin
                res_valid     = 1'b1;
                finished_next = 1'b1;
                if (acc_new[15:0] > held_shnum) begin
                  res.status = ST_STRNDX;
                end else begin
                  res.status                = ST_OK;
                  res.is_64bit              = is64;
                  res.big_endian            = big;
                  res.object_type           = held_type;
                  res.machine               = held_machine;
                  res.entry_point           = held_entry;
                  res.program_header_offset = held_phoff;
                  res.section_header_offset = held_shoff;
                  res.header_flags          = held_flags;
                  res.program_header_count  = held_phnum;
                  res.section_count         = held_shnum;
                  res.string_section_index  = acc_new[15:0];
                end
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      finished <= 1'b0;
      is64     <= 1'b0;
      big      <= 1'b0;
    end else begin
      pos      <= pos_next;
      finished <= finished_next;
      is64     <= is64_next;
      big      <= big_next;
    end
  end

  always_ff @(posedge clk) begin
    acc          <= acc_next;
    held_type    <= held_type_next;
    held_machine <= held_machine_next;
    held_entry   <= held_entry_next;
    held_phoff   <= held_phoff_next;
    held_shoff   <= held_shoff_next;
    held_flags   <= held_flags_next;
    held_phnum   <= held_phnum_next;
    held_shnum   <= held_shnum_next;
  end

  a_drop_after_result: assert property (@(posedge clk) disable iff (rst)
    (step && !item.end_of_stream && finished) |-> !res_valid)
    else $error("result while discarding bytes");

  a_finish_on_result: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_TRUNC) |=> finished)
    else $error("parser not finished after a result");

  a_eos_clears: assert property (@(posedge clk) disable iff (rst)
    (step && item.end_of_stream) |=> (pos == 7'd0 && !finished))
    else $error("end marker did not return parser to header start");

endmodule

### rtl/elf_header_parser.sv
// Top level of the object file header parser: input handshake and two-deep result buffer.
`timescale 1ns / 1ps

// Streaming object file header checker. One byte beat per cycle on item; the
// header state advances in the cycle the beat is taken. Magic, class, data
// encoding, ident version, pad bytes and the header version word are checked
// as they pass; the first failure produces an error result (all fields zero
// but status) and the remaining bytes are dropped until an end_of_stream beat,
// which quietly rearms the parser. At the last header byte (52 bytes for
// 32-bit, 64 for 64-bit files) one result carries the decoded fields, or
// status 7 when the string table index exceeds the section count. An
// end_of_stream beat before that produces a truncated result (status 8).
// Results go through a two-entry output buffer (output register plus skid
// register); item_ready drops only while both are full, so throughput is one
// byte per cycle as long as result is drained.
module elf_header_parser import ehp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  ehp_in_t  item,
  output logic     result_valid,
  input  logic     result_ready,
  output ehp_out_t result
);

  logic     step;
  logic     res_valid;
  ehp_out_t res;
  logic     push, pop;
  logic     skid_valid;
  ehp_out_t skid;

  assign item_ready = !skid_valid;
  assign step       = item_valid && item_ready;
  assign push       = res_valid;
  assign pop        = result_valid && result_ready;

  ehp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register, backed by a skid register when the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || pop) begin
      result_valid <= skid_valid || push;
      skid_valid   <= 1'b0;
    end else if (push) begin
      skid_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || pop) begin
      result <= skid_valid ? skid : res;
    end
    if (result_valid && !pop && push) begin
      skid <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid holds a beat while output register is empty");

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != ST_OK) |->
      (result.entry_point == 64'd0 && result.section_count == 16'd0 &&
       result.string_section_index == 16'd0 && !result.is_64bit))
    else $error("error result carries header fields");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid)
    else $error("skid beat lost");

endmodule

### tb/sv/elf_header_parser_test.sv
// Testbench for elf_header_parser: random object file headers, byte-level predictor, scoreboard.
`timescale 1ns / 1ps

module elf_header_parser_test;
  import ehp_pkg::*;

  // Ident byte values the parser accepts
  localparam logic [7:0]  CLASS_32      = 8'd1;
  localparam logic [7:0]  CLASS_64      = 8'd2;
  localparam logic [7:0]  DATA_LSB      = 8'd1;
  localparam logic [7:0]  DATA_MSB      = 8'd2;
  localparam logic [7:0]  IDENT_CURRENT = 8'd1;
  localparam logic [31:0] EV_CURRENT    = 32'd1;

  localparam int unsigned TARGET_BEATS   = 2000;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;

  // Tracks the parser state beat by beat and keeps the headers it owes us.
  class header_tracker;
    logic [6:0]  pos;
    bit          done;
    bit          is64;
    bit          big;
    logic [63:0] acc;
    logic [15:0] typ;
    logic [15:0] mach;
    logic [63:0] entry;
    logic [63:0] phoff;
    logic [63:0] shoff;
    logic [31:0] flags;
    logic [15:0] phnum;
    logic [15:0] shnum;
    ehp_out_t    pending_headers[$];
    int unsigned errors;

    function void clear();
      pos   = '0;
      done  = 1'b0;
      is64  = 1'b0;
      big   = 1'b0;
      acc   = '0;
      typ   = '0;
      mach  = '0;
      entry = '0;
      phoff = '0;
      shoff = '0;
      flags = '0;
      phnum = '0;
      shnum = '0;
    endfunction

    // Error results carry nothing but the status.
    function void owe_error(logic [3:0] code);
      ehp_out_t r;
      r = '0;
      r.status = code;
      pending_headers.push_back(r);
      done = 1'b1;
    endfunction

    function int unsigned field_bytes(fld_t f);
      case (f)
        FLD_ENTRY, FLD_PHOFF, FLD_SHOFF: return is64 ? 8 : 4;
        FLD_VERSION, FLD_FLAGS:          return 4;
        default:                         return 2;
      endcase
    endfunction

    function void take_beat(ehp_in_t b);
      logic [6:0]  p;
      int unsigned st;
      int unsigned len;
      fld_t        f;
      bit          hit;
      bit          was_done;
      ehp_out_t    r;
      if (b.end_of_stream) begin
        // end marker always rearms; it only reports when a header was open
        was_done = done;
        clear();
        if (!was_done) begin
          owe_error(ST_TRUNC);
          done = 1'b0;
        end
        return;
      end
      if (done) return;
      p   = pos;
      pos = pos + 7'd1;

      if (p < IDENT_LEN) begin
        case (p)
          ID_MAG0: if (b.data_byte != MAG0) owe_error(ST_MAGIC);
          ID_MAG1: if (b.data_byte != MAG1) owe_error(ST_MAGIC);
          ID_MAG2: if (b.data_byte != MAG2) owe_error(ST_MAGIC);
          ID_MAG3: if (b.data_byte != MAG3) owe_error(ST_MAGIC);
          ID_CLASS: begin
            if (b.data_byte != CLASS_32 && b.data_byte != CLASS_64) owe_error(ST_CLASS);
            else is64 = (b.data_byte == CLASS_64);
          end
          ID_DATA: begin
            if (b.data_byte != DATA_LSB && b.data_byte != DATA_MSB) owe_error(ST_ENCODING);
            else big = (b.data_byte == DATA_MSB);
          end
          ID_VERSION: if (b.data_byte != IDENT_CURRENT) owe_error(ST_IDVER);
          ID_OSABI, ID_ABIVER: ;
          default: if (b.data_byte != 8'h00) owe_error(ST_PAD);
        endcase
        return;
      end

      st  = IDENT_LEN;
      len = 0;
      hit = 1'b0;
      f   = FLD_TYPE;
      for (int i = 0; i <= int'(FLD_SHSTRNDX); i++) begin
        f   = fld_t'(i);
        len = field_bytes(f);
        if (p < st + len) begin
          hit = 1'b1;
          break;
        end
        st += len;
      end
      if (!hit) begin
        done = 1'b1;
        return;
      end

      if (p == st) acc = '0;
      if (big) acc = {acc[55:0], b.data_byte};
      else     acc = acc | (64'(b.data_byte) << (8 * (p - st)));
      if (p != st + len - 1) return;

      case (f)
        FLD_TYPE:    typ   = acc[15:0];
        FLD_MACHINE: mach  = acc[15:0];
        FLD_VERSION: if (acc[31:0] != EV_CURRENT) owe_error(ST_EVERSION);
        FLD_ENTRY:   entry = acc;
        FLD_PHOFF:   phoff = acc;
        FLD_SHOFF:   shoff = acc;
        FLD_FLAGS:   flags = acc[31:0];
        FLD_PHNUM:   phnum = acc[15:0];
        FLD_SHNUM:   shnum = acc[15:0];
        FLD_SHSTRNDX: begin
          if (acc[15:0] > shnum) begin
            owe_error(ST_STRNDX);
          end else begin
            r.status                = ST_OK;
            r.is_64bit              = is64;
            r.big_endian            = big;
            r.object_type           = typ;
            r.machine               = mach;
            r.entry_point           = entry;
            r.program_header_offset = phoff;
            r.section_header_offset = shoff;
            r.header_flags          = flags;
            r.program_header_count  = phnum;
            r.section_count         = shnum;
            r.string_section_index  = acc[15:0];
            pending_headers.push_back(r);
            done = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_header(ehp_out_t got);
      ehp_out_t want;
      if (pending_headers.size() == 0) begin
        $error("result beat with no header pending: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_headers.pop_front();
      cmp("status", want.status, got.status);
      cmp("is_64bit", want.is_64bit, got.is_64bit);
      cmp("big_endian", want.big_endian, got.big_endian);
      cmp("object_type", want.object_type, got.object_type);
      cmp("machine", want.machine, got.machine);
      cmp("entry_point", want.entry_point, got.entry_point);
      cmp("program_header_offset", want.program_header_offset, got.program_header_offset);
      cmp("section_header_offset", want.section_header_offset, got.section_header_offset);
      cmp("header_flags", want.header_flags, got.header_flags);
      cmp("program_header_count", want.program_header_count, got.program_header_count);
      cmp("section_count", want.section_count, got.section_count);
      cmp("string_section_index", want.string_section_index, got.string_section_index);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  ehp_in_t  item = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  ehp_out_t result;

  header_tracker sb;
  bit            send_calm;           // sender runs without gaps while set
  bit            recv_calm = 1'b0;    // receiver does not stall while set, but for the long hold-off
  bit            hold_output = 1'b0;  // request one long receiver hold-off
  int unsigned   beats_sent;

  elf_header_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Field values lean on the extremes: all zeros, all ones, else random.
  function automatic logic [63:0] pick_value(int unsigned nbytes);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    if (nbytes < 8) v = v & ((64'd1 << (8 * nbytes)) - 64'd1);
    return v;
  endfunction

  // Append a multi-byte field in the file's byte order.
  function automatic void put_bytes(ref logic [7:0] q[$], input logic [63:0] v,
                                    input int unsigned n, input bit big);
    for (int i = 0; i < n; i++) begin
      q.push_back(big ? v[8 * (n - 1 - i) +: 8] : v[8 * i +: 8]);
    end
  endfunction

  // Well-formed header with random content; strndx sits on, just past or
  // anywhere around shnum so both the ok and the strndx outcome show up.
  function automatic void build_header(ref logic [7:0] q[$], input bit is64, input bit big);
    int unsigned alen;
    logic [15:0] shnum;
    logic [15:0] strndx;
    alen = is64 ? 8 : 4;
    q = {MAG0, MAG1, MAG2, MAG3, is64 ? CLASS_64 : CLASS_32, big ? DATA_MSB : DATA_LSB,
         IDENT_CURRENT, 8'($urandom), 8'($urandom)};
    repeat (7) q.push_back(8'h00);
    put_bytes(q, pick_value(2), 2, big);       // object type
    put_bytes(q, pick_value(2), 2, big);       // machine
    put_bytes(q, 64'(EV_CURRENT), 4, big);     // format version
    put_bytes(q, pick_value(alen), alen, big); // entry
    put_bytes(q, pick_value(alen), alen, big); // program header offset
    put_bytes(q, pick_value(alen), alen, big); // section header offset
    put_bytes(q, pick_value(4), 4, big);       // flags
    put_bytes(q, pick_value(2), 2, big);       // header size
    put_bytes(q, pick_value(2), 2, big);       // program header entry size
    put_bytes(q, pick_value(2), 2, big);       // program header count
    put_bytes(q, pick_value(2), 2, big);       // section header entry size
    shnum = 16'(pick_value(2));
    case ($urandom_range(0, 3))
      0:       strndx = shnum;
      1:       strndx = shnum + 16'd1;
      2:       strndx = 16'($urandom_range(0, shnum));
      default: strndx = 16'($urandom);
    endcase
    put_bytes(q, 64'(shnum), 2, big);
    put_bytes(q, 64'(strndx), 2, big);
  endfunction

  // One beat on the input channel. Valid is only dropped when a gap follows,
  // so back-to-back beats never see valid lowered and raised in one step.
  task automatic send_beat(input logic [7:0] d, input logic eos);
    int unsigned gap;
    ehp_in_t     beat;
    beat.data_byte     = d;
    beat.end_of_stream = eos;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= beat;
    do @(posedge clk); while (!item_ready);
    sb.take_beat(beat);
    beats_sent++;
  endtask

  task automatic send_bytes(input logic [7:0] q[$]);
    foreach (q[i]) send_beat(q[i], 1'b0);
  endtask

  // One random file: mostly well-formed headers, then a corrupted byte in the
  // ident, type, machine or version, cut-short headers and plain noise. Every
  // file ends in an end marker, sometimes two.
  task automatic send_file();
    logic [7:0]  q[$];
    int unsigned kind;
    int unsigned cut;
    bit          is64;
    bit          big;
    kind      = $urandom_range(0, 99);
    is64      = 1'($urandom_range(0, 1));
    big       = 1'($urandom_range(0, 1));
    send_calm = ($urandom_range(0, 3) == 0);
    if (kind < 92) build_header(q, is64, big);
    if (kind >= 55 && kind < 80) begin
      q[$urandom_range(0, 23)] = 8'($urandom);
    end else if (kind >= 80 && kind < 92) begin
      cut = $urandom_range(0, q.size() - 1);
      while (q.size() > cut) void'(q.pop_back());
    end else if (kind >= 92) begin
      repeat ($urandom_range(0, 70)) q.push_back(8'($urandom));
    end
    send_bytes(q);
    // bytes past a result are dropped by the parser
    if (kind < 80) begin
      repeat ($urandom_range(0, 5)) send_beat(8'($urandom), 1'b0);
    end
    send_beat(8'($urandom), 1'b1);
    if ($urandom_range(0, 9) == 0) send_beat(8'($urandom), 1'b1);
  endtask

  // Result side: random stalls with calm stretches, plus one long hold-off.
  initial begin : drain
    int unsigned stall;
    bit          held_once;
    held_once = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) recv_calm = !recv_calm;
      if (hold_output && !held_once) begin
        stall     = HOLD_CYCLES;
        held_once = 1'b1;
      end else begin
        stall = recv_calm ? 0 : $urandom_range(0, 13);
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
      sb.check_header(result);
    end
  end

  initial begin : stimulus
    logic [7:0] script[$];
    sb = new;
    sb.clear();
    send_calm   = 1'b0;
    beats_sent  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // End marker at header start reports truncated, twice in a row; the
    // byte under an end marker is ignored.
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    // Bad magic, a discarded byte, then a silent rearm.
    script = {8'h00, 8'hFF};
    send_bytes(script);
    send_beat(8'h00, 1'b1);
    // Bad class, bad data encoding, bad ident version.
    script = {MAG0, MAG1, MAG2, MAG3, 8'h00};
    send_bytes(script);
    send_beat(8'h00, 1'b1);
    script = {MAG0, MAG1, MAG2, MAG3, CLASS_64, 8'hFF};
    send_bytes(script);
    send_beat(8'h00, 1'b1);
    script = {MAG0, MAG1, MAG2, MAG3, CLASS_32, DATA_MSB, 8'h00};
    send_bytes(script);
    send_beat(8'h00, 1'b1);

    // Back-pressure: receiver holds off while a burst of end markers, each
    // one a truncated result, fills the output buffer and stalls the input.
    send_calm   = 1'b1;
    hold_output = 1'b1;
    repeat (24) send_beat(8'h00, 1'b1);

    while (beats_sent < TARGET_BEATS) send_file();
    item_valid <= 1'b0;

    while (sb.pending_headers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_headers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### sim.f
rtl/ehp_pkg.sv
rtl/ehp_core.sv
rtl/elf_header_parser.sv
tb/sv/elf_header_parser_test.sv
